>>> rtl/u2cp_pkg.sv
// u2cp_pkg: types and constants shared by the UTF-8 decoder modules.
// No dependencies.
`default_nettype none

package u2cp_pkg;

  typedef logic [2:0] len_t;

  // Sequence lengths
  localparam len_t LEN_ASCII = 3'd0;
  localparam len_t LEN_ONE   = 3'd1;
  localparam len_t LEN_TWO   = 3'd2;
  localparam len_t LEN_THREE = 3'd3;
  localparam len_t LEN_FOUR  = 3'd4;
  localparam len_t LEN_FIVE  = 3'd5;
  localparam len_t LEN_SIX   = 3'd6;

  // Lead byte data masks
  localparam logic [7:0] MASK_ASCII = 8'h7f;
  localparam logic [7:0] MASK_CONT  = 8'h3f;
  localparam logic [7:0] MASK_TWO   = 8'h1f;
  localparam logic [7:0] MASK_THREE = 8'h0f;
  localparam logic [7:0] MASK_FOUR  = 8'h07;
  localparam logic [7:0] MASK_HIGH  = 8'h03;

  // Smallest legal value per sequence length
  localparam logic [31:0] MIN_TWO   = 32'h0000_0080;
  localparam logic [31:0] MIN_THREE = 32'h0000_0800;
  localparam logic [31:0] MIN_FOUR  = 32'h0001_0000;
  localparam logic [31:0] MIN_FIVE  = 32'h0020_0000;
  localparam logic [31:0] MIN_SIX   = 32'h0400_0000;

  typedef struct packed {
    len_t        remaining;
    logic [31:0] acc;
    len_t        open_len;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] code_point;
    len_t        seq_length;
    logic        overlong;
  } dec_result_t;

  function automatic logic [31:0] min_value(input len_t len);
    logic [31:0] m;
    unique case (len)
      LEN_TWO:   m = MIN_TWO;
      LEN_THREE: m = MIN_THREE;
      LEN_FOUR:  m = MIN_FOUR;
      LEN_FIVE:  m = MIN_FIVE;
      LEN_SIX:   m = MIN_SIX;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/u2cp_dec.sv
// u2cp_dec: one-byte decode step; next sequence state and optional result.
// Depends on u2cp_pkg.
`default_nettype none

module u2cp_dec
  import u2cp_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire dec_state_t state_i,
  output dec_state_t      state_o,
  output dec_result_t     result_o
);

  len_t        cls;
  logic [7:0]  mask;
  logic [31:0] acc_shift;
  len_t        rem_dec;

  always_comb begin
    priority casez (byte_i)
      8'b0???????: begin cls = LEN_ASCII; mask = MASK_ASCII; end
      8'b10??????: begin cls = LEN_ONE;   mask = MASK_CONT;  end
      8'b110?????: begin cls = LEN_TWO;   mask = MASK_TWO;   end
      8'b1110????: begin cls = LEN_THREE; mask = MASK_THREE; end
      8'b11110???: begin cls = LEN_FOUR;  mask = MASK_FOUR;  end
      8'b111110??: begin cls = LEN_FIVE;  mask = MASK_HIGH;  end
      default:     begin cls = LEN_SIX;   mask = MASK_HIGH;  end
    endcase
  end

  assign acc_shift = {state_i.acc[25:0], byte_i[5:0]};
  assign rem_dec   = state_i.remaining - 3'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.remaining == '0) begin
      if (cls == LEN_ASCII || cls == LEN_ONE) begin
        // ASCII or stray continuation: emit at once
        result_o.emit       = 1'b1;
        result_o.code_point = {24'd0, byte_i & mask};
        result_o.seq_length = LEN_ONE;
      end else begin
        state_o.acc       = {24'd0, byte_i & mask};
        state_o.open_len  = cls;
        state_o.remaining = cls - 3'd1;
      end
    end else begin
      // continuation bits taken unchecked
      state_o.acc       = acc_shift;
      state_o.remaining = rem_dec;
      if (rem_dec == '0) begin
        result_o.emit       = 1'b1;
        result_o.code_point = acc_shift;
        result_o.seq_length = state_i.open_len;
        result_o.overlong   = (acc_shift < min_value(state_i.open_len));
        state_o.open_len    = LEN_ASCII;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8_to_code_point_decoder.sv
// utf8_to_code_point_decoder: top level, sequence state and result register.
// Depends on u2cp_pkg and u2cp_dec.
//
//   channel | ports                                         | dir
//   --------+-----------------------------------------------+-----
//   in      | in_valid, in_ready, in_byte[7:0]              | in
//   out     | out_valid, out_ready, out_code_point[31:0],   | out
//           | out_seq_length[2:0], out_overlong             |
//
// One byte per cycle while in_ready is high; a result is registered and appears
// in the cycle after the byte that ends a sequence (or an ASCII / stray continuation byte).
// The single result register sets the rate: in_ready is high while it is
// empty or being drained in the same cycle.
// Synchronous active-low reset closes any open sequence and empties the
// result register. A stalled result holds the input until it is taken.
`default_nettype none

module utf8_to_code_point_decoder
  import u2cp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_code_point,
  output len_t             out_seq_length,
  output logic             out_overlong
);

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t result;
  logic        out_valid_r;
  logic [31:0] code_point_r;
  len_t        seq_length_r;
  logic        overlong_r;
  logic        in_fire;

  u2cp_dec u_dec (
    .byte_i   (in_byte),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (result)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire && result.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.emit) begin
      code_point_r <= result.code_point;
      seq_length_r <= result.seq_length;
      overlong_r   <= result.overlong;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = code_point_r;
  assign out_seq_length = seq_length_r;
  assign out_overlong   = overlong_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for utf8_to_code_point_decoder: byte stream in, code points out.
// Depends on u2cp_pkg and the decoder RTL; predicts each result and checks it
// in order, under random bursts on the input and random stalls on the output.
`timescale 1ns / 100ps

module testbench;
  import u2cp_pkg::*;

  typedef struct {
    logic [31:0] code_point;
    len_t        seq_length;
    logic        overlong;
  } code_point_t;

  class utf8_scoreboard;
    code_point_t pending_q[$];
    len_t        bytes_left;
    len_t        open_len;
    logic [31:0] acc;
    int          failures;

    function new();
      bytes_left = LEN_ASCII;
      open_len   = LEN_ASCII;
      acc        = '0;
      failures   = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function len_t lead_length(logic [7:0] b);
      if (b <= 8'h7f) return LEN_ASCII;
      if (b <= 8'hbf) return LEN_ONE;
      if (b <= 8'hdf) return LEN_TWO;
      if (b <= 8'hef) return LEN_THREE;
      if (b <= 8'hf7) return LEN_FOUR;
      if (b <= 8'hfb) return LEN_FIVE;
      return LEN_SIX;
    endfunction

    function logic [7:0] lead_mask(len_t l);
      case (l)
        LEN_ASCII: return MASK_ASCII;
        LEN_ONE:   return MASK_CONT;
        LEN_TWO:   return MASK_TWO;
        LEN_THREE: return MASK_THREE;
        LEN_FOUR:  return MASK_FOUR;
        default:   return MASK_HIGH;
      endcase
    endfunction

    function logic [31:0] floor_for(len_t l);
      case (l)
        LEN_TWO:   return MIN_TWO;
        LEN_THREE: return MIN_THREE;
        LEN_FOUR:  return MIN_FOUR;
        LEN_FIVE:  return MIN_FIVE;
        LEN_SIX:   return MIN_SIX;
        default:   return '0;
      endcase
    endfunction

    // Advance the decoder state by one accepted request byte.
    function void note_byte(logic [7:0] b);
      len_t        l;
      code_point_t r;
      if (bytes_left == LEN_ASCII) begin
        l = lead_length(b);
        if (l == LEN_ASCII || l == LEN_ONE) begin
          r.code_point = {24'h0, b & lead_mask(l)};
          r.seq_length = LEN_ONE;
          r.overlong   = 1'b0;
          pending_q.push_back(r);
        end else begin
          acc        = {24'h0, b & lead_mask(l)};
          open_len   = l;
          bytes_left = l - 3'd1;
        end
      end else begin
        // no continuation check: low six bits are taken whatever the byte
        acc        = {acc[25:0], b[5:0]};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == LEN_ASCII) begin
          r.code_point = acc;
          r.seq_length = open_len;
          r.overlong   = (acc < floor_for(open_len));
          pending_q.push_back(r);
          open_len = LEN_ASCII;
        end
      end
    endfunction

    function void check_result(logic [31:0] cp, len_t len, logic ovl);
      code_point_t e;
      if (pending_q.size() == 0) begin
        note_failure($sformatf("unexpected result cp=%h len=%0d ovl=%b", cp, len, ovl));
        return;
      end
      e = pending_q.pop_front();
      if (cp !== e.code_point || len !== e.seq_length || ovl !== e.overlong)
        note_failure($sformatf("mismatch: exp cp=%h len=%0d ovl=%b, got cp=%h len=%0d ovl=%b",
                               e.code_point, e.seq_length, e.overlong, cp, len, ovl));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_code_point;
  len_t        out_seq_length;
  logic        out_overlong;

  utf8_scoreboard sb;
  logic           hold_req;
  int             burst_left;
  int             sent;
  logic [7:0]     directed_bytes [0:25];

  utf8_to_code_point_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_seq_length (out_seq_length),
    .out_overlong   (out_overlong)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_code_point, out_seq_length, out_overlong);
  end

  // Receiver: stall pattern is re-chosen at random from four modes; one long hold-off on request.
  initial begin
    int mode;
    int cycle;
    bit held;
    mode      = 0;
    cycle     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (hold_req && !held) begin
        out_ready = 1'b0;
        repeat (200) @(negedge clk);
        held = 1'b1;
      end
      if (cycle % 48 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = ($urandom_range(0, 3) != 0);
        2:       out_ready = (cycle % 5 >= 2);
        default: out_ready = 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Offer one byte from a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_sequence();
    int         kind;
    int         n;
    logic [7:0] lead;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      offer(8'($urandom_range(0, 255)));
    end else if (kind < 15) begin
      offer(8'($urandom_range(0, 127)));
    end else if (kind < 20) begin
      offer(8'h80 | 8'($urandom_range(0, 63)));
    end else begin
      n = $urandom_range(2, 6);
      case (n)
        2:       lead = 8'hc0 | 8'($urandom_range(0, 31));
        3:       lead = 8'he0 | 8'($urandom_range(0, 15));
        4:       lead = 8'hf0 | 8'($urandom_range(0, 7));
        5:       lead = 8'hf8 | 8'($urandom_range(0, 3));
        default: lead = 8'hfc | 8'($urandom_range(0, 3));
      endcase
      // bare lead makes overlong forms likely
      if ($urandom_range(0, 4) == 0) lead = lead & ~(8'hff >> (n + 1));
      offer(lead);
      for (int i = 1; i < n; i++) begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : (8'h80 | 8'($urandom_range(0, 63)));
        offer(b);
      end
    end
  endtask

  initial begin
    int  wait_cycles;
    bit  hold_done;
    bit  pause_done;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    hold_req   = 1'b0;
    burst_left = 0;
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    // ASCII and stray continuation extremes, overlong two and three byte forms,
    // largest two and four byte values, five byte with non-continuation data,
    // six byte from 0xff filling all 32 bits
    directed_bytes = '{8'h00, 8'h7f, 8'h80, 8'hbf,
                       8'hc0, 8'h80, 8'hdf, 8'hbf,
                       8'he0, 8'h9f, 8'hbf,
                       8'hf7, 8'hbf, 8'hbf, 8'hbf,
                       8'hfb, 8'h41, 8'h00, 8'hff, 8'hc0,
                       8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_bytes[i]) offer(directed_bytes[i]);
    wait_drained();

    while (sent < 1100) begin
      send_sequence();
      if (sent >= 300 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (sent >= 700 && !pause_done) begin
        wait_drained();
        pause_done = 1'b1;
      end
    end
    in_valid = 1'b0;

    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (5) @(negedge clk);
    if (sb.pending_q.size() != 0)
      sb.note_failure($sformatf("%0d results never arrived", sb.pending_q.size()));

    if (sb.failures == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
